>>> design/generational_handle_table_top_macros.svh
// Assertion macros for the generational handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GHT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define GHT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define GHT_ASSERT(label, clk, rst, prop)
`define GHT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> design/ght_pkg.sv
// Types and constants shared by the generational handle table modules.
package ght_pkg;

  localparam int KEY_W = 32;
  localparam int ID_W  = 6;
  localparam int GEN_W = 16;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_LOOKUP   = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_FIND     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    handle_id;
    logic [GEN_W-1:0]   handle_gen;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    result_id;
    logic [GEN_W-1:0]   result_gen;
    logic [KEY_W-1:0]   result_key;
    logic [CNT_W-1:0]   live_count;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic scan_step;
    logic read_issue;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic scan_op;
    logic read_op;
  } dp_stat_t;

endpackage

>>> design/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ght_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/ght_ctrl.sv
// Controller state machine for the generational handle table.
module ght_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ght_pkg::dp_stat_t  stat,
  output ght_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            if (stat.scan_op) begin
              state <= S_SCAN;
            end else if (stat.read_op) begin
              state <= S_READ;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture    = (state == S_IDLE) && start;
    cmd.clear_step = (state == S_CLEAR);
    cmd.scan_step  = (state == S_SCAN);
    cmd.read_issue = (state == S_READ);
    cmd.finish     = (state == S_FINISH);
  end

endmodule

>>> design/ght_dp.sv
// Datapath of the generational handle table: slot store, scan and result logic.
module ght_dp #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_BITS   = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ght_pkg::req_t     req,
  input  ght_pkg::dp_cmd_t  cmd,
  output ght_pkg::dp_stat_t stat,
  output ght_pkg::rsp_t     rsp,
  output logic              done
);

  localparam int ADDR_W = $clog2(SLOT_COUNT);
  localparam int CNT_BITS = $clog2(SLOT_COUNT);
  localparam int WORD_W = KEY_BITS + GEN_BITS;

  logic [ADDR_W-1:0]   ptr;
  logic [ADDR_W-1:0]   paddr;
  logic                pend;

  ght_pkg::opcode_t    op;
  logic [KEY_BITS-1:0] key_q;
  logic [ADDR_W-1:0]   id_addr;
  logic                id_ok;
  logic [GEN_BITS-1:0] gen_q;

  logic                found;
  logic [ADDR_W-1:0]   found_id;
  logic [GEN_BITS-1:0] found_gen;
  logic                free_ok;
  logic [ADDR_W-1:0]   free_id;
  logic [GEN_BITS-1:0] free_gen;

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] count_next;
  ght_pkg::rsp_t       rsp_next;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [63:0]         key_wide;
  logic [KEY_BITS-1:0] key_in;
  logic                id_in_ok;
  logic [KEY_BITS-1:0] rkey;
  logic [GEN_BITS-1:0] rgen;
  logic                hit_key;
  logic                hit_free;
  logic                match_h;
  logic [GEN_BITS-1:0] new_gen;
  logic                fin_we;
  logic [ADDR_W-1:0]   fin_addr;
  logic [WORD_W-1:0]   fin_data;

  ght_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign key_wide = 64'(req.key);
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign id_in_ok = (req.handle_id != '0) && (32'(req.handle_id) < 32'(SLOT_COUNT));

  always_comb begin
    stat.clear_last = (ptr == ADDR_W'(SLOT_COUNT - 1));
    stat.scan_last  = (ptr == ADDR_W'(SLOT_COUNT - 1));
    stat.scan_op    = (req.opcode == ght_pkg::OP_REGISTER || req.opcode == ght_pkg::OP_FIND)
                      && (key_in != '0);
    stat.read_op    = (req.opcode == ght_pkg::OP_LOOKUP || req.opcode == ght_pkg::OP_RELEASE)
                      && id_in_ok;
  end

  assign rkey = ram_rdata[GEN_BITS +: KEY_BITS];
  assign rgen = ram_rdata[GEN_BITS-1:0];

  assign hit_key  = pend && !found && (rkey == key_q);
  assign hit_free = pend && !free_ok && (rkey == '0);
  assign match_h  = id_ok && (rkey != '0) && (rgen == gen_q);

  always_comb begin
    new_gen = GEN_BITS'(free_gen + GEN_BITS'(1));
    if (new_gen == '0) begin
      new_gen = GEN_BITS'(1);
    end
  end

  always_comb begin
    rsp_next.status     = ght_pkg::ST_MISS;
    rsp_next.result_id  = '0;
    rsp_next.result_gen = '0;
    rsp_next.result_key = '0;
    count_next          = count;
    fin_we              = 1'b0;
    fin_addr            = id_addr;
    fin_data            = {{KEY_BITS{1'b0}}, rgen};
    case (op)
      ght_pkg::OP_REGISTER: begin
        if (key_q != '0) begin
          if (found) begin
            rsp_next.status     = ght_pkg::ST_OK;
            rsp_next.result_id  = ght_pkg::ID_W'(found_id);
            rsp_next.result_gen = ght_pkg::GEN_W'(found_gen);
          end else if (free_ok) begin
            rsp_next.status     = ght_pkg::ST_OK;
            rsp_next.result_id  = ght_pkg::ID_W'(free_id);
            rsp_next.result_gen = ght_pkg::GEN_W'(new_gen);
            fin_we              = 1'b1;
            fin_addr            = free_id;
            fin_data            = {key_q, new_gen};
            count_next          = count + CNT_BITS'(1);
          end else begin
            rsp_next.status     = ght_pkg::ST_FULL;
          end
        end
      end
      ght_pkg::OP_FIND: begin
        if (key_q != '0 && found) begin
          rsp_next.status     = ght_pkg::ST_OK;
          rsp_next.result_id  = ght_pkg::ID_W'(found_id);
          rsp_next.result_gen = ght_pkg::GEN_W'(found_gen);
        end
      end
      ght_pkg::OP_LOOKUP: begin
        if (match_h) begin
          rsp_next.status     = ght_pkg::ST_OK;
          rsp_next.result_id  = ght_pkg::ID_W'(id_addr);
          rsp_next.result_gen = ght_pkg::GEN_W'(rgen);
          rsp_next.result_key = ght_pkg::KEY_W'(rkey);
        end
      end
      ght_pkg::OP_RELEASE: begin
        if (match_h) begin
          rsp_next.status     = ght_pkg::ST_OK;
          rsp_next.result_id  = ght_pkg::ID_W'(id_addr);
          rsp_next.result_gen = ght_pkg::GEN_W'(rgen);
          fin_we              = 1'b1;
          if (count != '0) begin
            count_next = count - CNT_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
    rsp_next.live_count = ght_pkg::CNT_W'(count_next);
  end

  always_comb begin
    ram_we    = cmd.clear_step || (cmd.finish && fin_we);
    ram_waddr = cmd.clear_step ? ptr : fin_addr;
    ram_wdata = cmd.clear_step ? '0 : fin_data;
    ram_raddr = cmd.read_issue ? id_addr : ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      pend    <= 1'b0;
      found   <= 1'b0;
      free_ok <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      pend <= cmd.scan_step;
      done <= cmd.finish;
      if (cmd.capture) begin
        ptr     <= ADDR_W'(1);
        found   <= 1'b0;
        free_ok <= 1'b0;
      end else begin
        if (cmd.clear_step || cmd.scan_step) begin
          ptr <= ptr + ADDR_W'(1);
        end
        if (hit_key) begin
          found <= 1'b1;
        end
        if (hit_free) begin
          free_ok <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr <= ptr;
    if (cmd.capture) begin
      op      <= req.opcode;
      key_q   <= key_in;
      id_addr <= ADDR_W'(req.handle_id);
      id_ok   <= id_in_ok;
      gen_q   <= GEN_BITS'(req.handle_gen);
    end
    if (hit_key) begin
      found_id  <= paddr;
      found_gen <= rgen;
    end
    if (hit_free) begin
      free_id  <= paddr;
      free_gen <= rgen;
    end
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> design/generational_handle_table_top.sv
// Top level of the generational handle table.
//
// Command channel: req is taken at a rising edge where start is high and busy
// is low. One result per command appears on rsp, marked by done high for a single
// cycle; the receiver always takes it and cannot stall the block.
// Steps from the accepting edge to the done cycle:
//   register and find with a nonzero key: the S_SCAN state reads slots
//   1 .. SLOT_COUNT-1 through the single RAM read port, one slot per cycle,
//   then S_DRAIN drains the last read and S_FINISH decides.
//   lookup/release of an in-range handle: read in S_READ, decide in S_FINISH.
//   rejected commands (zero key, handle id 0 or out of range): S_FINISH only.
// A new command can be accepted at the edge that ends the done cycle.
// After reset the block runs a clearing pass over every slot of the slot store
// with busy high; live_count restarts at zero.
`include "generational_handle_table_top_macros.svh"

module generational_handle_table_top #(
  parameter int SLOT_COUNT = 64,
  parameter int GEN_BITS   = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ght_pkg::req_t req,
  output logic          done,
  output ght_pkg::rsp_t rsp
);

  ght_pkg::dp_cmd_t  cmd;
  ght_pkg::dp_stat_t stat;
  logic              rsp_clear;

  ght_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ght_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp),
    .done (done)
  );

  assign rsp_clear = (rsp.result_id == '0) && (rsp.result_gen == '0) && (rsp.result_key == '0);

  `GHT_ASSERT(a_done_idle, clk, rst, done |-> !busy)
  `GHT_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `GHT_ASSERT(a_fail_zero, clk, rst, (done && rsp.status != ght_pkg::ST_OK) |-> rsp_clear)
  `GHT_ASSERT(a_finish_done, clk, rst, cmd.finish |=> done)

endmodule
